// ===== rtl/sacwt_pkg.sv =====
// Shared types, constants and helpers for the set-associative write-through cache.
`timescale 1ns / 1ps

package sacwt_pkg;

  localparam int WAYS_DEF       = 8;
  localparam int SETS_DEF       = 128;
  localparam int LINE_BYTES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAG,
    ST_ISSUE,
    ST_RD0,
    ST_RD1,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [2:0]  size_bytes;
    logic [31:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_addr;
    logic [6:0]  out_size;
    logic [31:0] out_data;
    logic        hit;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  off2;
    logic [2:0]  sz;
    logic [31:0] wdata;
    logic [31:0] w0;
    logic [31:0] w1;
    logic        w1_ok;
  } lane_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] m0;
    logic [31:0] m1;
  } lane_out_t;

  // byte mask for an access of 0..4 bytes
  function automatic logic [31:0] size_mask(input logic [2:0] sz);
    logic [31:0] m;
    case (sz)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/sacwt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sacwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sacwt_lanes.sv =====
// Byte-lane extract and merge across two adjacent line words.
`timescale 1ns / 1ps

module sacwt_lanes (
  input  sacwt_pkg::lane_in_t  li,
  output sacwt_pkg::lane_out_t lo
);
  import sacwt_pkg::*;

  logic [63:0] buf64;
  logic [63:0] raw64;
  logic [63:0] wsh;
  logic [63:0] merged;
  logic [7:0]  bem;
  logic [5:0]  sh;

  always_comb begin
    sh     = {1'b0, li.off2, 3'b000};
    buf64  = {(li.w1_ok ? li.w1 : 32'h0), li.w0};
    raw64  = {li.w1, li.w0};
    wsh    = {32'h0, li.wdata} << sh;
    bem    = 8'({4'b0, (li.sz >= 3'd4) ? 4'hf : 4'((5'd1 << li.sz) - 5'd1)} << li.off2);
    for (int b = 0; b < 8; b++) begin
      merged[b*8 +: 8] = bem[b] ? wsh[b*8 +: 8] : raw64[b*8 +: 8];
    end
    lo.rdata = 32'(buf64 >> sh) & size_mask(li.sz);
    lo.m0    = merged[31:0];
    lo.m1    = merged[63:32];
  end

endmodule

// ===== rtl/set_assoc_write_through_cache.sv =====
// Top level: set-associative write-through cache with no write-allocate.
//
// Input channel (in_valid/in_stall/in_item): read, write or line-fill word.
// Result channel (out_valid/out_stall/out_item): read data, fill request,
// write-through or protocol error, at most one result per request.
// One request is worked at a time. A read or write first reads the tag
// memory; a hit then addresses the data memory and reads one data word, or
// two when the bytes straddle a word inside the line, and the result then
// moves into the output register. Each fill word is written to the data
// memory as it is taken; the last one of a line also writes the tag row and
// then reads the pending request's data as a hit does. The data memory
// port gives one word per cycle. After reset a clearing pass writes every
// tag row invalid, one set a cycle, with in_stall high. A result waits in
// the output register while out_stall is high; the next request is taken
// meanwhile and waits before its result only while the output register
// stays full.
`timescale 1ns / 1ps

module set_assoc_write_through_cache #(
  parameter int WAYS       = sacwt_pkg::WAYS_DEF,
  parameter int SETS       = sacwt_pkg::SETS_DEF,
  parameter int LINE_BYTES = sacwt_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = sacwt_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sacwt_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sacwt_pkg::out_item_t out_item
);
  import sacwt_pkg::*;

  localparam int OB      = $clog2(LINE_BYTES);
  localparam int SB      = $clog2(SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int LW      = LINE_BYTES / 4;
  localparam int WD_W    = $clog2(LW);
  localparam int LINE_W  = SB + WAY_W;
  localparam int DA_W    = LINE_W + WD_W;
  localparam int TAG_W   = (ADDR_BITS > OB + SB) ? ADDR_BITS - OB - SB : 1;
  localparam int ENT_W   = TAG_W + 1;
  localparam int ROW_W   = WAYS * ENT_W;
  localparam logic [31:0] AMASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
    return TAG_W'({32'h0, a} >> (OB + SB));
  endfunction

  state_t state_r, state_nxt;

  logic [SB-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              op_wr_r, op_wr_nxt;
  logic [31:0]       cur_addr_r, cur_addr_nxt;
  logic [2:0]        cur_sz_r, cur_sz_nxt;
  logic [31:0]       cur_wd_r, cur_wd_nxt;
  logic              cur_hit_r, cur_hit_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [31:0]       w0_r, w0_nxt;
  logic              fill_pend_r, fill_pend_nxt;
  logic [LINE_W-1:0] fill_line_r, fill_line_nxt;
  logic [WD_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [31:0]       pend_addr_r, pend_addr_nxt;
  logic [2:0]        pend_sz_r, pend_sz_nxt;
  logic [ROW_W-1:0]  fill_row_r, fill_row_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r;
  logic              out_valid_r;

  logic              tag_we;
  logic [SB-1:0]     tag_waddr, tag_raddr;
  logic [ROW_W-1:0]  tag_wdata, tag_rdata;
  logic              dat_we;
  logic [DA_W-1:0]   dat_waddr, dat_raddr;
  logic [31:0]       dat_wdata, dat_rdata;

  lane_in_t          li;
  lane_out_t         lo;

  logic              in_acc;
  logic              out_free;
  logic [31:0]       in_maddr;
  logic [2:0]        in_sz;
  logic [SB-1:0]     cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic              hit_any;
  logic [WAY_W-1:0]  hit_way;
  logic              inv_any;
  logic [WAY_W-1:0]  inv_way;
  logic [WD_W-1:0]   w0_idx;
  logic              need_w1;
  logic              last_word;
  out_item_t         rd_res;
  out_item_t         wt_res;
  out_item_t         err_res;

  sacwt_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  sacwt_ram #(.WIDTH(32), .DEPTH(WAYS * SETS * LW)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  sacwt_lanes u_lanes (
    .li (li),
    .lo (lo)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign in_maddr  = in_item.addr & AMASK;
  assign in_sz     = (in_item.size_bytes > 3'd4) ? 3'd4 : in_item.size_bytes;
  assign cur_set   = cur_addr_r[OB +: SB];
  assign cur_tag   = tag_of(cur_addr_r);
  assign w0_idx    = cur_addr_r[2 +: WD_W];
  assign need_w1   = (({1'b0, cur_addr_r[1:0]} + cur_sz_r) > 3'd4) && (w0_idx != {WD_W{1'b1}});
  assign last_word = (fill_cnt_r == {WD_W{1'b1}});

  // way lookup over the set row
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (tag_rdata[k*ENT_W + TAG_W] && tag_rdata[k*ENT_W +: TAG_W] == cur_tag) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(k);
      end
      if (!tag_rdata[k*ENT_W + TAG_W]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(k);
      end
    end
  end

  always_comb begin
    li.off2  = cur_addr_r[1:0];
    li.sz    = cur_sz_r;
    li.wdata = cur_wd_r;
    li.w0    = (state_r == ST_RD0) ? dat_rdata : w0_r;
    li.w1    = dat_rdata;
    li.w1_ok = (state_r == ST_RD1);
  end

  always_comb begin
    err_res      = '0;
    err_res.kind = KIND_ERROR;

    rd_res          = '0;
    rd_res.kind     = KIND_READ;
    rd_res.out_addr = cur_addr_r;
    rd_res.out_size = {4'b0, cur_sz_r};
    rd_res.out_data = lo.rdata;
    rd_res.hit      = cur_hit_r;

    wt_res          = '0;
    wt_res.kind     = KIND_WRITE;
    wt_res.out_addr = cur_addr_r;
    wt_res.out_size = {4'b0, cur_sz_r};
    wt_res.out_data = cur_wd_r & size_mask(cur_sz_r);
    wt_res.hit      = cur_hit_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SB'(SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.cmd)
            CMD_FILL: begin
              if (!fill_pend_r) state_nxt = ST_OUT;
              else if (last_word) state_nxt = ST_ISSUE;
            end
            CMD_READ, CMD_WRITE: state_nxt = fill_pend_r ? ST_OUT : ST_TAG;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_TAG:   state_nxt = hit_any ? ST_ISSUE : ST_OUT;
      ST_ISSUE: state_nxt = ST_RD0;
      ST_RD0:   state_nxt = need_w1 ? ST_RD1 : ST_OUT;
      ST_RD1:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    op_wr_nxt     = op_wr_r;
    cur_addr_nxt  = cur_addr_r;
    cur_sz_nxt    = cur_sz_r;
    cur_wd_nxt    = cur_wd_r;
    cur_hit_nxt   = cur_hit_r;
    line_nxt      = line_r;
    w0_nxt        = w0_r;
    fill_pend_nxt = fill_pend_r;
    fill_line_nxt = fill_line_r;
    fill_cnt_nxt  = fill_cnt_r;
    pend_addr_nxt = pend_addr_r;
    pend_sz_nxt   = pend_sz_r;
    fill_row_nxt  = fill_row_r;
    res_nxt       = res_r;

    tag_we    = 1'b0;
    tag_waddr = fill_line_r[WAY_W +: SB];
    tag_wdata = fill_row_r;
    tag_raddr = in_maddr[OB +: SB];
    dat_we    = 1'b0;
    dat_waddr = {fill_line_r, fill_cnt_r};
    dat_wdata = in_item.wdata;
    dat_raddr = {line_r, w0_idx};

    for (int k = 0; k < WAYS; k++) begin
      if (WAY_W'(k) == fill_line_r[WAY_W-1:0]) begin
        tag_wdata[k*ENT_W +: ENT_W] = {1'b1, tag_of(pend_addr_r)};
      end
    end

    case (state_r)
      ST_CLEAR: begin
        tag_we      = 1'b1;
        tag_waddr   = clr_cnt_r;
        tag_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + SB'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.cmd)
            CMD_FILL: begin
              if (!fill_pend_r) begin
                res_nxt = err_res;
              end else begin
                dat_we = 1'b1;
                if (last_word) begin
                  tag_we        = 1'b1;
                  fill_cnt_nxt  = '0;
                  fill_pend_nxt = 1'b0;
                  op_wr_nxt     = 1'b0;
                  cur_addr_nxt  = pend_addr_r;
                  cur_sz_nxt    = pend_sz_r;
                  cur_hit_nxt   = 1'b0;
                  line_nxt      = fill_line_r;
                end else begin
                  fill_cnt_nxt = fill_cnt_r + WD_W'(1);
                end
              end
            end
            CMD_READ, CMD_WRITE: begin
              res_nxt      = err_res;
              op_wr_nxt    = (in_item.cmd == CMD_WRITE);
              cur_addr_nxt = in_maddr;
              cur_sz_nxt   = in_sz;
              cur_wd_nxt   = in_item.wdata;
            end
            default: res_nxt = err_res;
          endcase
        end
      end
      ST_TAG: begin
        cur_hit_nxt = hit_any;
        line_nxt    = {cur_set, hit_way};
        if (op_wr_r) begin
          res_nxt     = wt_res;
          res_nxt.hit = hit_any;
        end else if (!hit_any) begin
          res_nxt          = '0;
          res_nxt.kind     = KIND_FILL;
          res_nxt.out_addr = cur_addr_r & ~32'(LINE_BYTES - 1);
          res_nxt.out_size = 7'(LINE_BYTES);
          fill_pend_nxt    = 1'b1;
          fill_line_nxt    = {cur_set, inv_any ? inv_way : cur_addr_r[8 +: WAY_W]};
          fill_cnt_nxt     = '0;
          pend_addr_nxt    = cur_addr_r;
          pend_sz_nxt      = cur_sz_r;
          fill_row_nxt     = tag_rdata;
        end
      end
      ST_ISSUE: begin
        dat_raddr = {line_r, w0_idx};
      end
      ST_RD0: begin
        w0_nxt    = dat_rdata;
        dat_raddr = {line_r, w0_idx + WD_W'(1)};
        dat_we    = op_wr_r;
        dat_waddr = {line_r, w0_idx};
        dat_wdata = lo.m0;
        if (!need_w1) res_nxt = op_wr_r ? wt_res : rd_res;
      end
      ST_RD1: begin
        dat_we    = op_wr_r;
        dat_waddr = {line_r, w0_idx + WD_W'(1)};
        dat_wdata = lo.m1;
        res_nxt   = op_wr_r ? wt_res : rd_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      fill_pend_r <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fill_pend_r <= fill_pend_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_wr_r     <= op_wr_nxt;
    cur_addr_r  <= cur_addr_nxt;
    cur_sz_r    <= cur_sz_nxt;
    cur_wd_r    <= cur_wd_nxt;
    cur_hit_r   <= cur_hit_nxt;
    line_r      <= line_nxt;
    w0_r        <= w0_nxt;
    fill_line_r <= fill_line_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_sz_r   <= pend_sz_nxt;
    fill_row_r  <= fill_row_nxt;
    res_r       <= res_nxt;
    if (state_r == ST_OUT && out_free) begin
      out_r <= res_r;
    end
  end

endmodule

// ===== dv/tb_set_assoc_write_through_cache.sv =====
// Self-checking testbench for the set-associative write-through cache.
`timescale 1ns / 1ps

module tb_set_assoc_write_through_cache;
  import sacwt_pkg::*;

  localparam int NWAYS   = 8;
  localparam int NSETS   = 128;
  localparam int LBYTES  = 64;
  localparam int LWORDS  = LBYTES / 4;
  localparam int NLINES  = NWAYS * NSETS;
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  set_assoc_write_through_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache shadow state
  logic        sh_valid [NLINES];
  logic [18:0] sh_tag   [NLINES];
  logic [31:0] sh_words [NLINES*LWORDS];
  logic        sh_filling;
  int          sh_fill_line;
  logic [18:0] sh_fill_tag;
  int          sh_fill_cnt;
  logic [5:0]  sh_poff;
  logic [2:0]  sh_psize;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 0;
  int  n_bad = 0;
  int  cyc = 0;
  int  issued = 0;

  function automatic logic [7:0] line_byte(int ln, int b);
    logic [31:0] w;
    w = sh_words[ln*LWORDS + b/4];
    return w[8*(b%4) +: 8];
  endfunction

  function automatic logic [31:0] line_read(int ln, int off, int n);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < n; k++)
      if (off + k < LBYTES) r[8*k +: 8] = line_byte(ln, off + k);
    return r;
  endfunction

  function automatic out_item_t err_item();
    out_item_t o;
    o = '0;
    o.kind = KIND_ERROR;
    return o;
  endfunction

  task automatic predict_cache(input in_item_t rq);
    out_item_t o;
    int sz, off, set, ln, w, bi;
    logic [18:0] tg;
    bit hit;
    o = '0;
    sz = (rq.size_bytes > 4) ? 4 : rq.size_bytes;
    hit = 0;
    ln = 0;
    if (rq.cmd == CMD_FILL) begin
      if (!sh_filling) begin
        expected_results.push_back(err_item());
        return;
      end
      sh_words[sh_fill_line*LWORDS + sh_fill_cnt] = rq.wdata;
      if (sh_fill_cnt + 1 < LWORDS) begin
        sh_fill_cnt++;
        return;
      end
      sh_fill_cnt = 0;
      sh_filling = 0;
      sh_valid[sh_fill_line] = 1;
      sh_tag[sh_fill_line] = sh_fill_tag;
      o.kind = KIND_READ;
      o.out_addr = {sh_fill_tag, 7'(sh_fill_line / NWAYS), sh_poff};
      o.out_size = 7'(sh_psize);
      o.out_data = line_read(sh_fill_line, sh_poff, sh_psize);
      expected_results.push_back(o);
      return;
    end
    if (rq.cmd == CMD_BAD || sh_filling) begin
      expected_results.push_back(err_item());
      return;
    end
    off = rq.addr[5:0];
    set = rq.addr[12:6];
    tg = rq.addr[31:13];
    for (w = 0; w < NWAYS; w++)
      if (!hit && sh_valid[set*NWAYS + w] && sh_tag[set*NWAYS + w] == tg) begin
        hit = 1;
        ln = set*NWAYS + w;
      end
    o.out_addr = rq.addr;
    o.out_size = 7'(sz);
    o.hit = hit;
    if (rq.cmd == CMD_WRITE) begin
      if (hit)
        for (int k = 0; k < sz; k++)
          if (off + k < LBYTES) begin
            bi = ln*LWORDS + (off + k)/4;
            sh_words[bi][8*((off + k)%4) +: 8] = rq.wdata[8*k +: 8];
          end
      o.kind = KIND_WRITE;
      o.out_data = rq.wdata & size_mask(3'(sz));
    end else if (hit) begin
      o.kind = KIND_READ;
      o.out_data = line_read(ln, off, sz);
    end else begin
      ln = set*NWAYS + rq.addr[10:8];
      for (w = NWAYS - 1; w >= 0; w--)
        if (!sh_valid[set*NWAYS + w]) ln = set*NWAYS + w;
      sh_filling = 1;
      sh_fill_line = ln;
      sh_fill_tag = tg;
      sh_fill_cnt = 0;
      sh_poff = 6'(off);
      sh_psize = 3'(sz);
      o.kind = KIND_FILL;
      o.out_addr = {rq.addr[31:6], 6'd0};
      o.out_size = 7'(LBYTES);
      o.out_data = '0;
      o.hit = 0;
    end
    expected_results.push_back(o);
  endtask

  // driver: predicts each request at acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_cache(in_item);
        issued++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_item <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result %p", out_item);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e !== out_item) begin
            n_bad++;
            if (n_bad <= 10) $display("mismatch: expected %p, got %p", e, out_item);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > MAX_CYCLES) begin
      $display("set_assoc_write_through_cache regression: fail");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] c, logic [31:0] a, logic [2:0] s,
                                  logic [31:0] d);
    in_item_t r;
    r.cmd = c;
    r.addr = a;
    r.size_bytes = s;
    r.wdata = d;
    return r;
  endfunction

  // read miss followed by a full line of fill words
  task automatic queue_miss_fill(logic [31:0] a, logic [2:0] s);
    pending_reqs.push_back(mk(CMD_READ, a, s, $urandom));
    for (int i = 0; i < LWORDS; i++)
      pending_reqs.push_back(mk(CMD_FILL, $urandom, 3'($urandom), $urandom));
  endtask

  // addresses in a few sets with many tags so ways fill and evict
  function automatic logic [31:0] rand_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) < 8) begin
      a[12:6] = 7'($urandom_range(3));
      a[31:13] = 19'($urandom_range(11)) ^ {19{a[31]}};
    end
    return a;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [31:0] a;
    for (int i = 0; i < NLINES; i++) begin
      sh_valid[i] = 0;
      sh_tag[i] = '0;
    end
    sh_filling = 0;
    sh_fill_line = 0;
    sh_fill_tag = '0;
    sh_fill_cnt = 0;
    sh_poff = '0;
    sh_psize = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray fill, bad command, line-end crossing, all sizes
    pending_reqs.push_back(mk(CMD_FILL, 32'h0, 3'd4, 32'hdead_beef));
    pending_reqs.push_back(mk(CMD_BAD, 32'hffff_ffff, 3'd7, 32'hffff_ffff));
    pending_reqs.push_back(mk(CMD_WRITE, 32'hffff_fffe, 3'd7, 32'hffff_ffff));
    queue_miss_fill(32'hffff_fffe, 3'd4);
    pending_reqs.push_back(mk(CMD_READ, 32'h0000_0000, 3'd0, 32'h0));
    pending_reqs.push_back(mk(CMD_WRITE, 32'h1234_5000, 3'd1, 32'h0));
    pending_reqs.push_back(mk(CMD_BAD, 32'h0, 3'd0, 32'h0));
    for (int i = 0; i < LWORDS; i++)
      pending_reqs.push_back(mk(CMD_FILL, 32'h0, 3'd0, ~32'(i)));
    pending_reqs.push_back(mk(CMD_FILL, 32'h0, 3'd0, 32'h0));
    for (int s = 0; s < 8; s++) begin
      pending_reqs.push_back(mk(CMD_WRITE, 32'hffff_ffc0 + 32'(s * 9), 3'(s), $urandom));
      pending_reqs.push_back(mk(CMD_READ, 32'hffff_ffc0 + 32'(s * 7), 3'(s), 32'h0));
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? 70 : (ph == 4 ? 6 : 0);
      stall_pct = (ph == 2 || ph == 3) ? 70 : (ph == 4 ? 6 : 0);
      r = 0;
      while (r < 100) begin
        a = rand_addr();
        case ($urandom_range(9))
          0, 1, 2: begin
            pending_reqs.push_back(mk(CMD_READ, a, 3'($urandom), $urandom));
            if ($urandom_range(3) != 0)
              for (int i = 0; i < LWORDS; i++) begin
                pending_reqs.push_back(mk(CMD_FILL, $urandom, 3'($urandom), $urandom));
                r++;
              end
          end
          3, 4, 5, 6: pending_reqs.push_back(mk(CMD_READ, a, 3'($urandom), $urandom));
          7, 8: pending_reqs.push_back(mk(CMD_WRITE, a, 3'($urandom), $urandom));
          default: pending_reqs.push_back(mk(2'($urandom), a, 3'($urandom), $urandom));
        endcase
        r++;
      end
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      wait_drained();
    end

    if (n_bad == 0 && expected_results.size() == 0)
      $display("set_assoc_write_through_cache regression: pass");
    else
      $display("set_assoc_write_through_cache regression: fail");
    $finish;
  end

endmodule

// ===== set_assoc_write_through_cache.f =====
rtl/sacwt_pkg.sv
rtl/sacwt_ram.sv
rtl/sacwt_lanes.sv
rtl/set_assoc_write_through_cache.sv
dv/tb_set_assoc_write_through_cache.sv
